>>> rtl/slot_free_list_allocator_top_defines.svh
// assertion macros used by the allocator top
`ifndef SLOT_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define SLOT_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SFLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SFLA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SFLA_ASSERT(lbl, prop, msg)
`define SFLA_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/sfla_pkg.sv
`timescale 1ns / 1ps

package sfla_pkg;

  // store geometry
  localparam int unsigned SLOTS  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned LINK_W = IDX_W + 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  // item field widths
  localparam int unsigned ACTION_W     = 3;
  localparam int unsigned SLOT_FIELD_W = 6;
  localparam int unsigned STATUS_W     = 2;

  // end-of-list mark in a link or in the head
  localparam logic [LINK_W-1:0] LIST_END = LINK_W'(SLOTS);

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 3'd0,
    ACT_RESERVE = 3'd1,
    ACT_PUT     = 3'd2,
    ACT_MARK    = 3'd3,
    ACT_RELEASE = 3'd4
  } sfla_action_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK          = 2'd0,
    STS_FULL        = 2'd1,
    STS_WRONG_STATE = 2'd2
  } sfla_status_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EXEC   = 3'b010,
    ST_RELINK = 3'b100
  } sfla_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic relink;
  } sfla_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic relink_req;
    logic relink_last;
  } sfla_sts_t;

endpackage

>>> rtl/sfla_in_if.sv
`timescale 1ns / 1ps

interface sfla_in_if import sfla_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [ACTION_W-1:0]     action;
  logic [SLOT_FIELD_W-1:0] slot_index;
  logic [DATA_W-1:0]       write_data;

  modport source (output valid, action, slot_index, write_data, input ready);
  modport sink   (input valid, action, slot_index, write_data, output ready);
endinterface

>>> rtl/sfla_out_if.sv
`timescale 1ns / 1ps

interface sfla_out_if import sfla_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [SLOT_FIELD_W-1:0] granted_slot;
  logic [STATUS_W-1:0]     status;
  logic [CNT_W-1:0]        used_count;

  modport source (output valid, granted_slot, status, used_count, input ready);
  modport sink   (input valid, granted_slot, status, used_count, output ready);
endinterface

>>> rtl/sfla_ram.sv
`timescale 1ns / 1ps

module sfla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sfla_ctrl.sv
`timescale 1ns / 1ps

module sfla_ctrl import sfla_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sfla_sts_t sts_i,
  output sfla_cmd_t cmd_o
);

  sfla_state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.execute = 1'b1;
          state_d       = sts_i.relink_req ? ST_RELINK : ST_IDLE;
        end
      end
      ST_RELINK: begin
        cmd_o.relink = 1'b1;
        if (sts_i.relink_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/sfla_dp.sv
`timescale 1ns / 1ps

module sfla_dp import sfla_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sfla_cmd_t               cmd_i,
  output sfla_sts_t               sts_o,
  input  logic [ACTION_W-1:0]     action_i,
  input  logic [SLOT_FIELD_W-1:0] slot_index_i,
  input  logic [DATA_W-1:0]       write_data_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [SLOT_FIELD_W-1:0] granted_slot_o,
  output logic [STATUS_W-1:0]     status_o,
  output logic [CNT_W-1:0]        used_count_o
);

  // captured item
  logic [ACTION_W-1:0]     action_q;
  logic [SLOT_FIELD_W-1:0] index_q;
  logic [DATA_W-1:0]       data_q;

  // slot state
  logic [SLOTS-1:0]  used_q;
  logic [SLOTS-1:0]  link_vld_q;
  logic [LINK_W-1:0] head_q;
  logic [CNT_W-1:0]  count_q;

  // relink walk
  logic [IDX_W-1:0]  rl_cnt_q;
  logic [LINK_W-1:0] rl_next_q;
  logic              rl_free;

  // link read tracking
  logic [IDX_W-1:0]  rd_addr_q;
  logic              rd_vld_q;
  logic [LINK_W-1:0] link_rdata;
  logic [LINK_W-1:0] link_rd;

  // result register
  logic                    out_valid_q;
  logic [SLOT_FIELD_W-1:0] out_slot_q;
  logic [STATUS_W-1:0]     out_status_q;
  logic [CNT_W-1:0]        out_count_q;

  // action decode
  logic [IDX_W-1:0]        slot_addr;
  logic [IDX_W-1:0]        head_addr;
  logic                    in_range;
  logic                    used_at;
  logic                    full;
  logic [LINK_W-1:0]       nxt_head;
  logic [SLOT_FIELD_W-1:0] ex_slot;
  logic [STATUS_W-1:0]     ex_status;
  logic [CNT_W-1:0]        ex_count;
  logic [LINK_W-1:0]       ex_head;
  logic                    ex_used_we;
  logic [IDX_W-1:0]        ex_used_addr;
  logic                    ex_used_val;
  logic                    ex_link_we;
  logic [IDX_W-1:0]        ex_link_addr;
  logic [LINK_W-1:0]       ex_link_data;
  logic                    ex_data_we;
  logic [IDX_W-1:0]        ex_data_addr;
  logic                    ex_relink;

  // memory ports
  logic              link_we;
  logic [IDX_W-1:0]  link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic              data_we;

  assign slot_addr = index_q[IDX_W-1:0];
  assign head_addr = head_q[IDX_W-1:0];
  assign in_range  = ({1'b0, index_q} < (SLOT_FIELD_W + 1)'(SLOTS));
  assign used_at   = used_q[slot_addr];
  assign full      = (head_q >= LIST_END);
  assign rl_free   = !used_q[rl_cnt_q];

  // a link never written still holds its reset value i+1
  assign link_rd  = rd_vld_q ? link_rdata : (LINK_W'(rd_addr_q) + LINK_W'(1));
  assign nxt_head = (link_rd > LIST_END) ? LIST_END : link_rd;

  // effect of the captured item
  always_comb begin
    ex_slot      = index_q;
    ex_status    = STS_OK;
    ex_count     = count_q;
    ex_head      = head_q;
    ex_used_we   = 1'b0;
    ex_used_addr = slot_addr;
    ex_used_val  = 1'b1;
    ex_link_we   = 1'b0;
    ex_link_addr = slot_addr;
    ex_link_data = LIST_END;
    ex_data_we   = 1'b0;
    ex_data_addr = slot_addr;
    ex_relink    = 1'b0;
    case (action_q)
      ACT_ALLOC, ACT_RESERVE: begin
        if (full) begin
          ex_status = STS_FULL;
        end else begin
          ex_slot      = SLOT_FIELD_W'(head_addr);
          ex_used_we   = 1'b1;
          ex_used_addr = head_addr;
          ex_count     = count_q + CNT_W'(1);
          ex_link_we   = 1'b1;
          ex_link_addr = head_addr;
          ex_data_we   = (action_q == ACT_ALLOC);
          ex_data_addr = head_addr;
          ex_head      = nxt_head;
        end
      end
      ACT_PUT: begin
        if (!in_range) begin
          ex_status = STS_WRONG_STATE;
        end else begin
          ex_data_we = 1'b1;
          if (!used_at) begin
            ex_used_we = 1'b1;
            ex_count   = count_q + CNT_W'(1);
            ex_relink  = 1'b1;
          end
        end
      end
      ACT_MARK: begin
        if (!in_range || used_at) begin
          ex_status = STS_WRONG_STATE;
        end else begin
          ex_used_we = 1'b1;
          ex_count   = count_q + CNT_W'(1);
          ex_relink  = 1'b1;
        end
      end
      ACT_RELEASE: begin
        if (!in_range || !used_at) begin
          ex_status = STS_WRONG_STATE;
        end else begin
          ex_used_we   = 1'b1;
          ex_used_val  = 1'b0;
          ex_count     = count_q - CNT_W'(1);
          ex_link_we   = 1'b1;
          ex_link_data = head_q;
          ex_head      = LINK_W'(slot_addr);
        end
      end
      default: begin
        ex_status = STS_OK;
      end
    endcase
  end

  // link port: relink walk or item write
  always_comb begin
    if (cmd_i.relink) begin
      link_we    = 1'b1;
      link_waddr = rl_cnt_q;
      link_wdata = rl_free ? rl_next_q : LIST_END;
    end else begin
      link_we    = cmd_i.execute && ex_link_we;
      link_waddr = ex_link_addr;
      link_wdata = ex_link_data;
    end
  end

  assign data_we = cmd_i.execute && ex_data_we;

  sfla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (head_addr),
    .rdata_o (link_rdata)
  );

  sfla_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOTS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (ex_data_addr),
    .wdata_i (data_q),
    .raddr_i ('0),
    .rdata_o ()
  );

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      index_q  <= slot_index_i;
      data_q   <= write_data_i;
    end
    rd_addr_q <= head_addr;
  end

  // slot state, walk and link read valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      link_vld_q <= '0;
      head_q     <= '0;
      count_q    <= '0;
      rl_cnt_q   <= '0;
      rl_next_q  <= LIST_END;
      rd_vld_q   <= 1'b0;
    end else begin
      rd_vld_q <= link_vld_q[head_addr];
      if (link_we) begin
        link_vld_q[link_waddr] <= 1'b1;
      end
      if (cmd_i.execute) begin
        count_q   <= ex_count;
        head_q    <= ex_head;
        rl_cnt_q  <= IDX_W'(SLOTS - 1);
        rl_next_q <= LIST_END;
        if (ex_used_we) begin
          used_q[ex_used_addr] <= ex_used_val;
        end
      end
      if (cmd_i.relink) begin
        rl_cnt_q <= rl_cnt_q - IDX_W'(1);
        if (rl_free) begin
          rl_next_q <= LINK_W'(rl_cnt_q);
        end
        if (rl_cnt_q == '0) begin
          head_q <= rl_free ? LINK_W'(rl_cnt_q) : rl_next_q;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.execute) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      out_slot_q   <= ex_slot;
      out_status_q <= ex_status;
      out_count_q  <= ex_count;
    end
  end

  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.relink_req  = ex_relink;
  assign sts_o.relink_last = (rl_cnt_q == '0);

  assign out_valid_o    = out_valid_q;
  assign granted_slot_o = out_slot_q;
  assign status_o       = out_status_q;
  assign used_count_o   = out_count_q;

endmodule

>>> rtl/slot_free_list_allocator_top.sv
// Slot allocator: 64 slots, each with a used flag, a 32-bit data word and a
// link in a free list.
// in_i carries one item: action (allocate, reserve, put, mark used, release),
// slot_index and write_data. out_o returns one item per input item:
// granted_slot, status (ok, full, wrong used state) and used_count.
// An accepted item is captured, then executed once the output register is
// free, and its result sits in the output register from then on. in_i.ready
// is low while a captured item waits, so a new item is taken only after the
// last one is executed. A put or mark used that claims a free slot then
// rebuilds the free list in ascending order, walking the link memory one slot
// per cycle, while in_i.ready stays low.
// Reset: all slots free, list runs 0 to 63, used count zero; no clearing pass
// is needed, a link never written reads as its reset value.
// Stall: the result waits in the output register while out_o.ready is low;
// the next item is still accepted and waits in execution until that register
// is free.
`timescale 1ns / 1ps
`include "slot_free_list_allocator_top_defines.svh"

module slot_free_list_allocator_top import sfla_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  sfla_in_if.sink    in_i,
  sfla_out_if.source out_o
);

  sfla_cmd_t cmd;
  sfla_sts_t sts;
  logic      in_ready;

  // sequencer
  sfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot state and result register
  sfla_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (in_i.action),
    .slot_index_i   (in_i.slot_index),
    .write_data_i   (in_i.write_data),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .granted_slot_o (out_o.granted_slot),
    .status_o       (out_o.status),
    .used_count_o   (out_o.used_count)
  );

  assign in_i.ready = in_ready;

  // checks
  `SFLA_ASSERT(a_full_means_all_used, (out_o.valid && out_o.status == STS_FULL) |-> (out_o.used_count == CNT_W'(SLOTS)), "full status with free slots left")
  `SFLA_ASSERT(a_count_in_range, out_o.valid |-> (out_o.used_count <= CNT_W'(SLOTS)), "used count above slot count")
  `SFLA_ASSERT_NEVER(a_no_accept_in_relink, cmd.relink && in_ready, "input taken during relink")
  `SFLA_ASSERT(a_exec_needs_room, cmd.execute |-> sts.out_free, "result overwrote a waiting result")

endmodule
